[hw/rtl/rau_pkg.sv]
// Shared constants for the rational arithmetic unit: command codes and result widths.
package rau_pkg;

    // Width of the command selector and its codes.
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SIMP   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RECIP  = 3'd5;

    // Results are kept modulo 2^RES_W.
    localparam int RES_W = 33;

    // Result word: numerator and denominator packed, padded to whole bytes.
    localparam int M_TDATA_W = ((2 * RES_W + 7) / 8) * 8;

endpackage

[hw/rtl/rau_mult.sv]
// Registered signed multiplier whose product is wrapped to the result width.
module rau_mult
    import rau_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                    aclk,
    input  logic signed [W-1:0]     op_a,
    input  logic signed [W-1:0]     op_b,
    output logic        [RES_W-1:0] prod
);

    logic signed [2*W-1:0] full;
    logic [RES_W-1:0]      prod_next;
    logic [RES_W-1:0]      prod_reg;

    // Full-width signed product.
    assign full = op_a * op_b;

    // Fit the product to the result width: truncate or sign extend.
    generate
        if (2 * W >= RES_W) begin : g_trunc
            assign prod_next = full[RES_W-1:0];
        end else begin : g_ext
            assign prod_next = RES_W'(full);
        end
    endgenerate

    // Product register, loaded from the operands of the previous cycle.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/rau_divider.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
module rau_divider
    import rau_pkg::*;
#(
    parameter int W = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W:0]       shifted;
    logic [W+1:0]     diff;
    logic             fits;

    // Bring down the next dividend bit and try a subtraction.
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !diff[W+1];

    // Next-state logic for one restoring step.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // A new division is only started once the previous one has finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // The last step is always followed by the done pulse.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && cnt_reg == CNT_W'(1)) |=> done_reg)
        else $error("divider finished without done");

    // A finished remainder is smaller than the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("divider remainder not reduced");

endmodule

[hw/rtl/rational_arithmetic_unit_top.sv]
// Top level of the rational arithmetic unit: sequencer, operand registers and output register.
//
// The slave channel takes one word per operation: s_tuser carries the command and
// s_tdata the two fractions. The master channel returns one word per operation with
// the result numerator and denominator, each 33 bits two's complement.
// An operand denominator of zero is taken as one.
// Add, subtract, multiply and divide run three passes through one registered
// multiplier, going from dispatch through the mul passes to write.
// Simplify runs Euclid's algorithm on a shared bit-serial divider, one division per
// remainder step, followed by two exact divisions by the gcd. At the default width
// there are at most 22 remainder steps. Reciprocal and unused commands go from
// dispatch straight to write.
// One operation is in flight at a time; s_tready is high only while the unit is idle,
// so the next word is accepted in the cycle in which the result word appears at the earliest.
// A finished result waits in the output register, and the next word is accepted
// while it waits; if the receiver still stalls when the next result is ready,
// the sequencer holds that result until the output register frees up.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_tvalid.
module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    // Fields from bit 0: first_num, first_den, second_num, second_den.
    input  logic [((4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0]  s_tdata,
    // Fields from bit 0: cmd.
    input  logic [CMD_W-1:0]                                s_tuser,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    // Fields from bit 0: result_num, result_den.
    output logic [M_TDATA_W-1:0]                            m_tdata
);

    localparam int W = OPERAND_WIDTH;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_MUL      = 3'd2;
    localparam logic [2:0] ST_GCD_CHK  = 3'd3;
    localparam logic [2:0] ST_GCD_WAIT = 3'd4;
    localparam logic [2:0] ST_QN_WAIT  = 3'd5;
    localparam logic [2:0] ST_QD_WAIT  = 3'd6;
    localparam logic [2:0] ST_WRITE    = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         step_reg, step_next;
    logic               odd_reg, odd_next;
    logic               gneg_reg, gneg_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic signed [W-1:0] an_reg, an_next;
    logic signed [W-1:0] ad_reg, ad_next;
    logic signed [W-1:0] bn_reg, bn_next;
    logic signed [W-1:0] bd_reg, bd_next;
    logic [W-1:0]       x_reg, x_next;
    logic [W-1:0]       y_reg, y_next;
    logic [RES_W-1:0]   num_reg, num_next;
    logic [RES_W-1:0]   den_reg, den_next;
    logic [RES_W-1:0]   out_num_reg, out_num_next;
    logic [RES_W-1:0]   out_den_reg, out_den_next;

    logic signed [W-1:0] in_an, in_ad, in_bn, in_bd;
    logic               s_accept;
    logic               out_free;
    logic [W-1:0]       an_mag, ad_mag;
    logic signed [W-1:0] mul_a, mul_b;
    logic [RES_W-1:0]   prod;
    logic               div_start;
    logic [W-1:0]       div_dividend, div_divisor;
    logic               div_done;
    logic [W-1:0]       div_quotient, div_remainder;
    logic [RES_W-1:0]   q_ext;

    // Unpack the input word.
    assign in_an = s_tdata[W-1:0];
    assign in_ad = s_tdata[2*W-1:W];
    assign in_bn = s_tdata[3*W-1:2*W];
    assign in_bd = s_tdata[4*W-1:3*W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Magnitudes of the first fraction for the gcd datapath.
    assign an_mag = an_reg[W-1] ? W'(-an_reg) : W'(an_reg);
    assign ad_mag = ad_reg[W-1] ? W'(-ad_reg) : W'(ad_reg);

    // Multiplier operand pairs for the three product passes.
    always_comb begin
        case (step_reg)
            2'd0: begin
                mul_a = an_reg;
                mul_b = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
            end
            2'd1: begin
                mul_a = ad_reg;
                mul_b = (cmd_reg == CMD_MUL) ? bd_reg : bn_reg;
            end
            default: begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    rau_mult #(.W(W)) u_mult (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Divider requests: a Euclid remainder step, then the two exact divisions by g.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = ad_mag;
        div_divisor  = x_reg;
        if (state_reg == ST_GCD_CHK) begin
            div_start = 1'b1;
            if (y_reg != '0) begin
                div_dividend = x_reg;
                div_divisor  = y_reg;
            end else begin
                div_dividend = an_mag;
            end
        end else if (state_reg == ST_QN_WAIT && div_done) begin
            div_start = 1'b1;
        end
    end

    rau_divider #(.W(W)) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign q_ext = RES_W'(div_quotient);

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        odd_next      = odd_reg;
        gneg_next     = gneg_reg;
        cmd_next      = cmd_reg;
        an_next       = an_reg;
        ad_next       = ad_reg;
        bn_next       = bn_reg;
        bd_next       = bd_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        out_num_next  = out_num_reg;
        out_den_next  = out_den_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next   = s_tuser;
                    an_next    = in_an;
                    ad_next    = (in_ad == '0) ? W'(1) : in_ad;
                    bn_next    = in_bn;
                    bd_next    = (in_bd == '0) ? W'(1) : in_bd;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (cmd_reg)
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                        step_next  = 2'd0;
                        state_next = ST_MUL;
                    end
                    CMD_SIMP: begin
                        x_next     = an_mag;
                        y_next     = ad_mag;
                        odd_next   = 1'b0;
                        state_next = ST_GCD_CHK;
                    end
                    CMD_RECIP: begin
                        num_next   = RES_W'(ad_reg);
                        den_next   = RES_W'(an_reg);
                        state_next = ST_WRITE;
                    end
                    default: begin
                        num_next   = RES_W'(an_reg);
                        den_next   = RES_W'(ad_reg);
                        state_next = ST_WRITE;
                    end
                endcase
            end
            ST_MUL: begin
                // Each pass captures the product issued in the previous cycle.
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd1: num_next = prod;
                    2'd2: begin
                        if (cmd_reg == CMD_ADD) begin
                            num_next = num_reg + prod;
                        end else if (cmd_reg == CMD_SUB) begin
                            num_next = num_reg - prod;
                        end else begin
                            den_next = prod;
                        end
                    end
                    2'd3: begin
                        if (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB) begin
                            den_next = prod;
                        end else if (cmd_reg == CMD_DIV && bn_reg == '0) begin
                            num_next = '0;
                            den_next = RES_W'(1);
                        end
                        state_next = ST_WRITE;
                    end
                    default: ;
                endcase
            end
            ST_GCD_CHK: begin
                if (y_reg != '0) begin
                    state_next = ST_GCD_WAIT;
                end else begin
                    // The sign of g follows the operand at the same parity.
                    gneg_next  = odd_reg ? ad_reg[W-1] : an_reg[W-1];
                    state_next = ST_QN_WAIT;
                end
            end
            ST_GCD_WAIT: begin
                if (div_done) begin
                    x_next     = y_reg;
                    y_next     = div_remainder;
                    odd_next   = !odd_reg;
                    state_next = ST_GCD_CHK;
                end
            end
            ST_QN_WAIT: begin
                if (div_done) begin
                    num_next   = (an_reg[W-1] ^ gneg_reg) ? (RES_W'(0) - q_ext) : q_ext;
                    state_next = ST_QD_WAIT;
                end
            end
            ST_QD_WAIT: begin
                if (div_done) begin
                    den_next   = (ad_reg[W-1] ^ gneg_reg) ? (RES_W'(0) - q_ext) : q_ext;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    out_num_next  = num_reg;
                    out_den_next  = den_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= 2'd0;
            odd_reg      <= 1'b0;
            gneg_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            odd_reg      <= odd_next;
            gneg_reg     <= gneg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Operand and result registers.
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2 * RES_W){1'b0}}, out_den_reg, out_num_reg};

    // Denominators are never zero once an operation is under way.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (ad_reg != '0 && bd_reg != '0))
        else $error("zero denominator reached the datapath");

    // Euclid never ends with a zero gcd.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GCD_CHK && y_reg == '0) |-> (x_reg != '0))
        else $error("gcd came out as zero");

    // A new result word only appears after the write state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_WRITE))
        else $error("result word raised outside the write state");

endmodule

[bench/tb.sv]
// Self-checking testbench for the rational arithmetic unit with a fraction predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int OPW       = 16;
    localparam int S_TDATA_W = ((4 * OPW + 7) / 8) * 8;
    // Command codes that the unit passes through as the first fraction.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
    // Cycle budget: slowest simplify plus both stalls per word, taken several times over.
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 500;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic signed [RES_W-1:0] den;
        logic signed [RES_W-1:0] num;
    } fraction_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    fraction_t pending_fractions[$];
    int        fail_count  = 0;
    int        cycle_count = 0;
    bit        idle_on     = 1'b0;
    bit        hold_req    = 1'b0;

    rational_arithmetic_unit_top #(
        .OPERAND_WIDTH(OPW)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Exact fraction arithmetic on sign-extended operands, kept modulo 2^RES_W.
    function automatic fraction_t rational_result(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [OPW-1:0] p_num,
                                                  input logic signed [OPW-1:0] p_den,
                                                  input logic signed [OPW-1:0] q_num,
                                                  input logic signed [OPW-1:0] q_den);
        longint    an, ad, bn, bd, rn, rd, a, b, r;
        fraction_t f;
        an = p_num;
        ad = p_den;
        bn = q_num;
        bd = q_den;
        if (ad == 0) ad = 1;
        if (bd == 0) bd = 1;
        case (cmd)
            CMD_ADD: begin
                rn = an * bd + ad * bn;
                rd = ad * bd;
            end
            CMD_SUB: begin
                rn = an * bd - ad * bn;
                rd = ad * bd;
            end
            CMD_MUL: begin
                rn = an * bn;
                rd = ad * bd;
            end
            CMD_DIV: begin
                rn = an * bd;
                rd = ad * bn;
                if (rd == 0) begin
                    rn = 0;
                    rd = 1;
                end
            end
            CMD_SIMP: begin
                // Euclid with truncated remainder; the gcd may come out negative.
                a = an;
                b = ad;
                while (b != 0) begin
                    r = a % b;
                    a = b;
                    b = r;
                end
                if (a != 0) begin
                    rn = an / a;
                    rd = ad / a;
                end else begin
                    rn = an;
                    rd = ad;
                end
            end
            CMD_RECIP: begin
                rn = ad;
                rd = an;
            end
            default: begin
                rn = an;
                rd = ad;
            end
        endcase
        f.num = rn[RES_W-1:0];
        f.den = rd[RES_W-1:0];
        return f;
    endfunction

    // Offer one word, wait for its acceptance and record the expected fraction.
    task automatic send_op(input logic [CMD_W-1:0] cmd, input int an, input int ad,
                           input int bn, input int bd);
        logic signed [OPW-1:0] p_num, p_den, q_num, q_den;
        p_num = an[OPW-1:0];
        p_den = ad[OPW-1:0];
        q_num = bn[OPW-1:0];
        q_den = bd[OPW-1:0];
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {q_den, q_num, p_den, p_num};
        do @(posedge aclk); while (!s_tready);
        pending_fractions.push_back(rational_result(cmd, p_num, p_den, q_num, q_den));
    endtask

    // Operand mix: extremes, small values and full-range values.
    function automatic int pick_operand();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel < 2) begin
            case ($urandom_range(0, 4))
                0: return -(1 << (OPW - 1));
                1: return (1 << (OPW - 1)) - 1;
                2: return 0;
                3: return 1;
                default: return -1;
            endcase
        end
        if (sel < 6) return int'($urandom_range(0, 40)) - 20;
        return int'($urandom);
    endfunction

    task automatic send_random_op();
        logic [CMD_W-1:0] cmd;
        int               k;
        cmd = CMD_W'($urandom_range(0, 7));
        if (cmd == CMD_SIMP && $urandom_range(0, 1) == 1) begin
            // Fractions with a known common factor, so reduction does real work.
            k = int'($urandom_range(1, 200));
            send_op(cmd, k * (int'($urandom_range(0, 300)) - 150),
                    k * (int'($urandom_range(0, 300)) - 150), pick_operand(), pick_operand());
        end else begin
            send_op(cmd, pick_operand(), pick_operand(), pick_operand(), pick_operand());
        end
    endtask

    // Extremes of every field, each command, zero denominators and the division by zero.
    task automatic test_directed();
        send_op(CMD_ADD, 32767, 32767, 32767, 32767);
        send_op(CMD_ADD, -32768, -32768, -32768, -32768);
        send_op(CMD_ADD, 0, 0, 0, 0);
        send_op(CMD_SUB, 32767, -32768, -32768, 32767);
        send_op(CMD_SUB, -32768, 32767, 32767, -32768);
        send_op(CMD_MUL, -32768, 1, -32768, 1);
        send_op(CMD_MUL, 3, 0, 5, 0);
        send_op(CMD_DIV, 1, 2, 0, 3);
        send_op(CMD_DIV, -32768, -32768, -32768, -32768);
        send_op(CMD_DIV, 5, 0, -7, 0);
        send_op(CMD_SIMP, 12, -18, 0, 0);
        send_op(CMD_SIMP, 0, 5, 1, 1);
        send_op(CMD_SIMP, 0, -32768, 0, 0);
        send_op(CMD_SIMP, -32768, 0, 0, 0);
        send_op(CMD_SIMP, -32768, -32768, 0, 0);
        send_op(CMD_SIMP, 32767, -1, 0, 0);
        send_op(CMD_SIMP, 17, 23, -1, -1);
        send_op(CMD_RECIP, 0, 7, 0, 0);
        send_op(CMD_RECIP, -32768, 0, 32767, 32767);
        send_op(CMD_SPARE_A, 5, 0, 9, 9);
        send_op(CMD_SPARE_B, -32768, 32767, -1, 0);
    endtask

    task automatic test_random_with_idling(input int count);
        idle_on = 1'b1;
        repeat (count) send_random_op();
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_output_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (10) send_random_op();
    endtask

    task automatic test_random_full_rate(input int count);
        idle_on = 1'b0;
        repeat (count) send_random_op();
    endtask

    // Receiver: random stall bursts, plus one long hold when asked for.
    initial begin : result_sink
        int hold_left;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                m_tready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge aclk);
                    hold_left--;
                end
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string field, input logic signed [RES_W-1:0] want,
                                   input logic signed [RES_W-1:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Compare each result word with the oldest expected fraction.
    always @(posedge aclk) begin : result_check
        fraction_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.num = m_tdata[RES_W-1:0];
            got.den = m_tdata[2*RES_W-1:RES_W];
            if (pending_fractions.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected word, expected none, actual %0d/%0d",
                         $time, got.num, got.den);
            end else begin
                want = pending_fractions.pop_front();
                if (got.num !== want.num) report_mismatch("result_num", want.num, got.num);
                if (got.den !== want.den) report_mismatch("result_den", want.den, got.den);
            end
        end
    end

    // Cycle counter that ends a hung run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin : main
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_with_idling(1300);
        test_output_backpressure();
        test_random_full_rate(420);
        s_tvalid <= 1'b0;

        // Let every expected word arrive, then watch for stray ones.
        while (pending_fractions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
